/* hw/rtl/letbp_pkg.sv */
// Shared constants for the LE entry table bundle parser.
// Used by letbp_parser and le_entry_table_bundle_parser; no dependencies.
`default_nettype none

package letbp_pkg;

	localparam int ORDINAL_BITS_DEFAULT = 16;
	localparam int OFFSET_BITS_DEFAULT  = 16;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int OBJ_W   = 16;
	localparam int RUN_W   = 8;
	localparam int INDEX_W = 3;

	// Bundle type codes as they appear in the type byte.
	localparam logic [BYTE_W-1:0] KIND_UNUSED = 8'd0;
	localparam logic [BYTE_W-1:0] KIND_16BIT  = 8'd1;
	localparam logic [BYTE_W-1:0] KIND_32BIT  = 8'd3;

	// Entry sizes: flags byte plus a 2-byte or 4-byte offset.
	localparam logic [INDEX_W-1:0] ENTRY_BYTES_16 = 3'd3;
	localparam logic [INDEX_W-1:0] ENTRY_BYTES_32 = 3'd5;

endpackage

`default_nettype wire

/* hw/rtl/letbp_parser.sv */
// Bundle recognizer: holds the parse state and turns one table byte into
// at most one result per step. Depends on letbp_pkg.
`default_nettype none

module letbp_parser import letbp_pkg::*; #(
	parameter int ORDINAL_BITS = ORDINAL_BITS_DEFAULT,
	parameter int OFFSET_BITS  = OFFSET_BITS_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire logic [BYTE_W-1:0]       table_byte,
	input  wire logic                    last_byte,
	output logic                         emit,
	output logic [ORDINAL_BITS-1:0]      first_ordinal,
	output logic [RUN_W-1:0]             run_length,
	output logic [KIND_W-1:0]            entry_kind,
	output logic [OBJ_W-1:0]             object_number,
	output logic [OFFSET_BITS-1:0]       byte_offset
);

	localparam int ORD_W = ORDINAL_BITS + 1;
	localparam logic [ORD_W-1:0] ORD_LIMIT = {1'b1, {ORDINAL_BITS{1'b0}}};
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_TYPE,
		PH_OBJ_LO,
		PH_OBJ_HI,
		PH_ENTRY
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [RUN_W-1:0]       left_q, left_d;
	logic [KIND_W-1:0]      kind_q, kind_d;
	logic [OBJ_W-1:0]       obj_q, obj_d;
	logic [ORD_W-1:0]       ord_q, ord_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [INDEX_W-1:0]     idx_q, idx_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic                   ended_q, ended_d;

	logic [ORD_W-1:0]       ord_sum;
	logic [ORD_W-1:0]       ord_room;
	logic [INDEX_W-1:0]     idx_inc;
	logic [INDEX_W-1:0]     entry_size;
	logic [RUN_W-1:0]       left_dec;
	logic                   ord_full;

	assign ord_full   = ord_q[ORDINAL_BITS];
	assign ord_sum    = ord_q + ORD_W'(left_q);
	assign ord_room   = ORD_LIMIT - ord_q;
	assign idx_inc    = idx_q + 3'd1;
	assign entry_size = (kind_q == KIND_32BIT[KIND_W-1:0]) ? ENTRY_BYTES_32 : ENTRY_BYTES_16;
	assign left_dec   = (left_q != '0) ? left_q - 8'd1 : left_q;

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		kind_d  = kind_q;
		obj_d   = obj_q;
		ord_d   = ord_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		start_d = start_q;
		ended_d = ended_q;

		emit          = 1'b0;
		first_ordinal = ord_q[ORDINAL_BITS-1:0];
		run_length    = 8'd1;
		entry_kind    = kind_q;
		object_number = obj_q;
		byte_offset   = start_q;

		if (step) begin
			if (!ended_q) begin
				unique case (phase_q)
					PH_COUNT: begin
						if (table_byte == '0 || last_byte) begin
							ended_d = 1'b1;
						end else begin
							left_d  = table_byte;
							phase_d = PH_TYPE;
						end
					end
					PH_TYPE: begin
						if (last_byte) begin
							ended_d = 1'b1;
						end else if (table_byte == KIND_UNUSED) begin
							if (!ord_full) begin
								emit          = 1'b1;
								entry_kind    = KIND_UNUSED[KIND_W-1:0];
								object_number = '0;
								byte_offset   = (pos_q == OFF_MAX) ? OFF_MAX : pos_q + 1'b1;
								// A run that crosses the ordinal limit is cut to fit.
								if (ord_sum > ORD_LIMIT) begin
									run_length = ord_room[RUN_W-1:0];
									ord_d      = ORD_LIMIT;
								end else begin
									run_length = left_q;
									ord_d      = ord_sum;
								end
							end
							phase_d = PH_COUNT;
						end else if (table_byte == KIND_16BIT || table_byte == KIND_32BIT) begin
							kind_d  = table_byte[KIND_W-1:0];
							phase_d = PH_OBJ_LO;
						end else begin
							ended_d = 1'b1;
						end
					end
					PH_OBJ_LO: begin
						obj_d   = {8'h00, table_byte};
						phase_d = PH_OBJ_HI;
					end
					PH_OBJ_HI: begin
						obj_d   = {table_byte, obj_q[7:0]};
						idx_d   = '0;
						phase_d = PH_ENTRY;
					end
					PH_ENTRY: begin
						if (idx_q == '0) begin
							start_d = pos_q;
						end
						if (idx_inc >= entry_size) begin
							idx_d = '0;
							if (!ord_full) begin
								emit  = 1'b1;
								ord_d = ord_q + 1'b1;
							end
							left_d = left_dec;
							if (left_dec == '0) begin
								phase_d = PH_COUNT;
							end
						end else begin
							idx_d = idx_inc;
						end
					end
					default: begin
						phase_d = PH_COUNT;
					end
				endcase
			end

			pos_d = (pos_q == OFF_MAX) ? OFF_MAX : pos_q + 1'b1;

			// The last byte closes the table; the next byte starts a fresh one.
			if (last_byte) begin
				phase_d = PH_COUNT;
				left_d  = '0;
				kind_d  = '0;
				obj_d   = '0;
				ord_d   = '0;
				pos_d   = '0;
				idx_d   = '0;
				start_d = '0;
				ended_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			left_q  <= '0;
			kind_q  <= '0;
			obj_q   <= '0;
			ord_q   <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			start_q <= '0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			kind_q  <= kind_d;
			obj_q   <= obj_d;
			ord_q   <= ord_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
			start_q <= start_d;
			ended_q <= ended_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/le_entry_table_bundle_parser.sv */
// LE entry table bundle parser, top level. A byte goes through the input
// register and the combinational parse step into the result register.
// Throughput: one byte per cycle while the result register is free or
// drains, set by the parse step between the two registers. Reset (arst_n
// low) clears all parse state; the block expects a count byte afterwards.
`default_nettype none

module le_entry_table_bundle_parser import letbp_pkg::*; #(
	parameter int ORDINAL_BITS = ORDINAL_BITS_DEFAULT,
	parameter int OFFSET_BITS  = OFFSET_BITS_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [BYTE_W-1:0]       table_byte,
	input  wire logic                    last_byte,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [ORDINAL_BITS-1:0]      first_ordinal,
	output logic [RUN_W-1:0]             run_length,
	output logic [KIND_W-1:0]            entry_kind,
	output logic [OBJ_W-1:0]             object_number,
	output logic [OFFSET_BITS-1:0]       byte_offset
);

	logic                    valid_s1;
	logic [BYTE_W-1:0]       byte_s1;
	logic                    last_s1;

	logic                    advance;
	logic                    emit;
	logic [ORDINAL_BITS-1:0] ord_c;
	logic [RUN_W-1:0]        run_c;
	logic [KIND_W-1:0]       kind_c;
	logic [OBJ_W-1:0]        obj_c;
	logic [OFFSET_BITS-1:0]  off_c;

	logic                    out_valid_q;
	logic [ORDINAL_BITS-1:0] ord_q;
	logic [RUN_W-1:0]        run_q;
	logic [KIND_W-1:0]       kind_q;
	logic [OBJ_W-1:0]        obj_q;
	logic [OFFSET_BITS-1:0]  off_q;

	// The staged item moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= table_byte;
			last_s1 <= last_byte;
		end
	end

	letbp_parser #(
		.ORDINAL_BITS (ORDINAL_BITS),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.table_byte    (byte_s1),
		.last_byte     (last_s1),
		.emit          (emit),
		.first_ordinal (ord_c),
		.run_length    (run_c),
		.entry_kind    (kind_c),
		.object_number (obj_c),
		.byte_offset   (off_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ord_q  <= ord_c;
			run_q  <= run_c;
			kind_q <= kind_c;
			obj_q  <= obj_c;
			off_q  <= off_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign first_ordinal = ord_q;
	assign run_length    = run_q;
	assign entry_kind    = kind_q;
	assign object_number = obj_q;
	assign byte_offset   = off_q;

`ifndef SYNTHESIS
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> run_length != '0)
		else $error("result with zero run length");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_kind == KIND_UNUSED[KIND_W-1:0]
			|| entry_kind == KIND_16BIT[KIND_W-1:0]
			|| entry_kind == KIND_32BIT[KIND_W-1:0]))
		else $error("result with unknown bundle type");

	a_entry_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_kind != KIND_UNUSED[KIND_W-1:0] |-> run_length == 8'd1)
		else $error("entry result covers more than one ordinal");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while result register is empty");
`endif

endmodule

`default_nettype wire
